FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is low
`define LPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpc assertion failed");

// next-cycle implication, quiet while reset is low
`define LPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpc assertion failed");

`endif

FILE: rtl/lpc_pkg.sv
package lpc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_BLEND_CONTROL     = 3'd0;
  localparam logic [2:0] REG_ALPHA_COEF_FIRST  = 3'd1;
  localparam logic [2:0] REG_ALPHA_COEF_SECOND = 3'd2;
  localparam logic [2:0] REG_FADE_COEF         = 3'd3;
  localparam logic [2:0] REG_BACKDROP_COLOR    = 3'd4;

  // effect select in blend_control bits 7:6
  localparam logic [1:0] EFF_NONE   = 2'd0;
  localparam logic [1:0] EFF_BLEND  = 2'd1;
  localparam logic [1:0] EFF_BRIGHT = 2'd2;
  localparam logic [1:0] EFF_DARK   = 2'd3;

  // arithmetic mode carried down the pipe
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_MIX  = 2'd1;
  localparam logic [1:0] MODE_UP   = 2'd2;
  localparam logic [1:0] MODE_DOWN = 2'd3;

  localparam logic [5:0] CHAN_MAX = 6'h3F;

  typedef struct packed {
    logic [31:0] attr;
    logic [22:0] color;
  } lpc_layer_t;

  typedef struct packed {
    lpc_layer_t top;
    lpc_layer_t sec;
    logic       win;
  } lpc_sort_t;

  typedef struct packed {
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    logic [4:0] a;
  } lpc_pix_t;

  // insert one layer into the two lowest attribute words
  function automatic lpc_sort_t lpc_insert(lpc_sort_t s, logic [31:0] a, logic [22:0] c);
    lpc_sort_t o;
    o = s;
    if (a < s.top.attr) begin
      o.sec       = s.top;
      o.top.attr  = a;
      o.top.color = c;
    end else if (a < s.sec.attr) begin
      o.sec.attr  = a;
      o.sec.color = c;
    end
    return o;
  endfunction

  // bgr555 doubled, or direct 6-bit channels with 5-bit alpha
  function automatic lpc_pix_t lpc_expand(logic [22:0] c, logic direct);
    lpc_pix_t p;
    if (direct) begin
      p.r = c[5:0];
      p.g = c[11:6];
      p.b = c[17:12];
      p.a = c[22:18];
    end else begin
      p.r = {c[4:0], 1'b0};
      p.g = {c[9:5], 1'b0};
      p.b = {c[14:10], 1'b0};
      p.a = 5'h1F;
    end
    return p;
  endfunction

  function automatic logic [5:0] lpc_clamp16(logic [4:0] k);
    return (k > 5'd16) ? 6'd16 : {1'b0, k};
  endfunction

endpackage

FILE: rtl/layer_pixel_compositor.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+------------------------------------
// pixel in  | input     | in_valid_i / in_ready_o    | sprite/bg0..bg3 color+attr, window
// pixel out | output    | out_valid_o / out_ready_i  | red_o, green_o, blue_o
// config    | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one pixel per clock sustained while out_ready_i stays high
// there are six register stages (sort, sort, sort, setup, multiply, sum)
// reset clears all stage valid bits and the configuration registers
// each stage loads whenever it is empty or the stage after it moves, so bubbles close up
// a held result at the output stalls only the stages behind it that are full
// config writes are always taken
module layer_pixel_compositor import lpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [22:0] sprite_color_i,
  input  logic [31:0] sprite_attr_i,
  input  logic [22:0] bg0_color_i,
  input  logic [31:0] bg0_attr_i,
  input  logic [22:0] bg1_color_i,
  input  logic [31:0] bg1_attr_i,
  input  logic [22:0] bg2_color_i,
  input  logic [31:0] bg2_attr_i,
  input  logic [22:0] bg3_color_i,
  input  logic [31:0] bg3_attr_i,
  input  logic        window_effects_i,
  // pixel out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  red_o,
  output logic [5:0]  green_o,
  output logic [5:0]  blue_o,
  // config
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] ctl_q;
  logic [4:0]  ka_q;
  logic [4:0]  kb_q;
  logic [4:0]  ky_q;
  logic [14:0] back_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      ka_q   <= '0;
      kb_q   <= '0;
      ky_q   <= '0;
      back_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BLEND_CONTROL:     ctl_q  <= cfg_data_i;
        REG_ALPHA_COEF_FIRST:  ka_q   <= cfg_data_i[4:0];
        REG_ALPHA_COEF_SECOND: kb_q   <= cfg_data_i[4:0];
        REG_FADE_COEF:         ky_q   <= cfg_data_i[4:0];
        REG_BACKDROP_COLOR:    back_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage valid bits and advance chain
  // ---------------------------------------------------------------------------
  logic [6:1] v_q;
  logic [7:1] adv;

  always_comb begin
    adv[7] = out_ready_i;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[1];
  assign out_valid_o = v_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= in_valid_i;
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
      if (adv[4]) v_q[4] <= v_q[3];
      if (adv[5]) v_q[5] <= v_q[4];
      if (adv[6]) v_q[6] <= v_q[5];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: backdrop, sprite over backdrop, then bg0
  // ---------------------------------------------------------------------------
  lpc_sort_t s1_d, s1_q;
  lpc_sort_t s2_d, s2_q;
  lpc_sort_t s3_d, s3_q;
  // bg1..bg3 ride along until their insertion stage
  logic [54:0] bg1_q, bg2_q, bg3_q, bg3_s2_q;

  logic [31:0] back_attr;
  logic [31:0] spr_en;

  // backdrop targets come from control bits 5 and 13, sprite ones from 4 and 12
  assign back_attr = {2'b01, 21'd0, ctl_q[13], 7'd0, ctl_q[5]};
  assign spr_en    = {23'd0, ctl_q[12], 7'd0, ctl_q[4]};

  always_comb begin
    lpc_sort_t s;
    s.top.attr  = back_attr;
    s.top.color = {8'd0, back_q};
    s.sec       = s.top;
    s.win       = window_effects_i;
    // the sprite can only ever land over the backdrop
    if (sprite_attr_i < back_attr) begin
      s.top.attr  = sprite_attr_i | spr_en;
      s.top.color = sprite_color_i;
    end
    s1_d = lpc_insert(s, bg0_attr_i, bg0_color_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_q  <= s1_d;
      bg1_q <= {bg1_attr_i, bg1_color_i};
      bg2_q <= {bg2_attr_i, bg2_color_i};
      bg3_q <= {bg3_attr_i, bg3_color_i};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: insert bg1 and bg2
  // ---------------------------------------------------------------------------
  always_comb begin
    lpc_sort_t s;
    s    = lpc_insert(s1_q, bg1_q[54:23], bg1_q[22:0]);
    s2_d = lpc_insert(s, bg2_q[54:23], bg2_q[22:0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_q     <= s2_d;
      bg3_s2_q <= bg3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: insert bg3
  // ---------------------------------------------------------------------------
  assign s3_d = lpc_insert(s2_q, bg3_s2_q[54:23], bg3_s2_q[22:0]);

  always_ff @(posedge clk_i) begin
    if (adv[3]) s3_q <= s3_d;
  end

  // ---------------------------------------------------------------------------
  // stage 4: expand colors and pick the operation and weights
  // result = c (pass), sat((x*k1 + y*k2 + rnd) >> sh) (mix),
  //          c + ((x*k1 + rnd) >> 4) with x = 63 - c (up), c - ((c*k1 + rnd) >> 4) (down)
  // ---------------------------------------------------------------------------
  logic [5:0] s4_x_d [3];
  logic [5:0] s4_y_d [3];
  logic [5:0] s4_c_d [3];
  logic [5:0] s4_k1_d, s4_k2_d;
  logic [4:0] s4_rnd_d;
  logic       s4_sh5_d;
  logic [1:0] s4_mode_d;

  logic [5:0] s4_x_q [3];
  logic [5:0] s4_y_q [3];
  logic [5:0] s4_c_q [3];
  logic [5:0] s4_k1_q, s4_k2_q;
  logic [4:0] s4_rnd_q;
  logic       s4_sh5_q;
  logic [1:0] s4_mode_q;

  always_comb begin
    lpc_pix_t   p0, p1;
    logic       top_fx, bot_fx;
    logic [3:0] pa;
    logic [5:0] eva, evb, evy;
    p0     = lpc_expand(s3_q.top.color, s3_q.top.attr[2]);
    p1     = lpc_expand(s3_q.sec.color, s3_q.sec.attr[2]);
    top_fx = s3_q.top.attr[0] && s3_q.win;
    bot_fx = s3_q.sec.attr[8] && s3_q.win;
    pa     = s3_q.top.attr[15:12];
    eva    = lpc_clamp16(ka_q);
    evb    = lpc_clamp16(kb_q);
    evy    = lpc_clamp16(ky_q);

    s4_c_d[0] = p0.r;
    s4_c_d[1] = p0.g;
    s4_c_d[2] = p0.b;
    s4_x_d    = s4_c_d;
    s4_y_d[0] = p1.r;
    s4_y_d[1] = p1.g;
    s4_y_d[2] = p1.b;
    s4_k1_d   = '0;
    s4_k2_d   = '0;
    s4_rnd_d  = 5'd8;
    s4_sh5_d  = 1'b0;
    s4_mode_d = MODE_PASS;

    if (s3_q.top.attr[1] && bot_fx) begin
      // semi-transparent top layer over a target in an effects window: alpha blend, no further effect
      s4_mode_d = MODE_MIX;
      if (s3_q.top.attr[2]) begin
        s4_k1_d  = {1'b0, p0.a} + 6'd1;
        s4_k2_d  = 6'd32 - s4_k1_d;
        s4_rnd_d = 5'd16;
        s4_sh5_d = 1'b1;
      end else if (pa != 4'd0) begin
        s4_k1_d = {2'b00, pa} + 6'd1;
        s4_k2_d = 6'd15 - {2'b00, pa};
      end else begin
        s4_k1_d = eva;
        s4_k2_d = evb;
      end
    end else if (top_fx) begin
      case (ctl_q[7:6])
        EFF_BLEND: begin
          if (bot_fx) begin
            s4_mode_d = MODE_MIX;
            s4_k1_d   = eva;
            s4_k2_d   = evb;
          end
        end
        EFF_BRIGHT: begin
          s4_mode_d = MODE_UP;
          s4_k1_d   = evy;
          for (int i = 0; i < 3; i++) begin
            s4_x_d[i] = CHAN_MAX - s4_c_d[i];
            s4_y_d[i] = '0;
          end
        end
        EFF_DARK: begin
          s4_mode_d = MODE_DOWN;
          s4_k1_d   = evy;
          s4_rnd_d  = 5'd7;
          for (int i = 0; i < 3; i++) begin
            s4_y_d[i] = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_x_q    <= s4_x_d;
      s4_y_q    <= s4_y_d;
      s4_c_q    <= s4_c_d;
      s4_k1_q   <= s4_k1_d;
      s4_k2_q   <= s4_k2_d;
      s4_rnd_q  <= s4_rnd_d;
      s4_sh5_q  <= s4_sh5_d;
      s4_mode_q <= s4_mode_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: weight products, two small multipliers per channel
  // ---------------------------------------------------------------------------
  logic [11:0] s5_p1_d [3];
  logic [11:0] s5_p2_d [3];
  logic [11:0] s5_p1_q [3];
  logic [11:0] s5_p2_q [3];
  logic [5:0]  s5_c_q  [3];
  logic [4:0]  s5_rnd_q;
  logic        s5_sh5_q;
  logic [1:0]  s5_mode_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_p1_d[i] = 12'(s4_x_q[i]) * 12'(s4_k1_q);
      s5_p2_d[i] = 12'(s4_y_q[i]) * 12'(s4_k2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_p1_q   <= s5_p1_d;
      s5_p2_q   <= s5_p2_d;
      s5_c_q    <= s4_c_q;
      s5_rnd_q  <= s4_rnd_q;
      s5_sh5_q  <= s4_sh5_q;
      s5_mode_q <= s4_mode_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: sum, round, scale, saturate mix results into the output register
  // ---------------------------------------------------------------------------
  logic [5:0] s6_d [3];
  logic [5:0] s6_q [3];

  always_comb begin
    logic [12:0] sum;
    logic [8:0]  q;
    for (int i = 0; i < 3; i++) begin
      sum = 13'(s5_p1_q[i]) + 13'(s5_p2_q[i]) + 13'(s5_rnd_q);
      q   = s5_sh5_q ? 9'(sum >> 5) : 9'(sum >> 4);
      case (s5_mode_q)
        MODE_MIX:  s6_d[i] = (q > 9'(CHAN_MAX)) ? CHAN_MAX : q[5:0];
        MODE_UP:   s6_d[i] = s5_c_q[i] + q[5:0];
        MODE_DOWN: s6_d[i] = s5_c_q[i] - q[5:0];
        default:   s6_d[i] = s5_c_q[i];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) s6_q <= s6_d;
  end

  assign red_o   = s6_q[0];
  assign green_o = s6_q[1];
  assign blue_o  = s6_q[2];

endmodule

FILE: rtl/lpc_checker.sv
`include "assert_macros.svh"

module lpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] red_o,
  input logic [5:0] green_o,
  input logic [5:0] blue_o
);

  logic        out_held;
  logic [17:0] pix_rgb;

  assign out_held = out_valid_o && !out_ready_i;
  assign pix_rgb  = {red_o, green_o, blue_o};

  // a result that is not taken stays, unchanged
  `LPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(pix_rgb))

  // input back-pressure only ever comes from a held result
  `LPC_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_held)

  // an empty output slot means the pipe can take a pixel
  `LPC_ASSERT_NOW(a_empty_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)

endmodule

bind layer_pixel_compositor lpc_checker u_lpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);
